FILE: rtl/core/rmh_pkg.sv
`timescale 1ns / 1ps
package rmh_pkg;

   // sizes
   localparam int CAPACITY     = 1024;
   localparam int SAMPLE_WIDTH = 32;
   localparam int HEAP_DEPTH   = CAPACITY / 2 + 2;
   localparam int IDX_W        = $clog2(HEAP_DEPTH);
   localparam int CNT_W        = $clog2(HEAP_DEPTH + 1);
   localparam int TOTAL_W      = 11;
   localparam int MED_W        = 33;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   // heap selector
   typedef enum logic {
      HEAP_LOWER = 1'b0,
      HEAP_UPPER = 1'b1
   } heap_sel_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } heap_op_type;

   // command from the sequencer to the heap unit
   typedef struct packed {
      logic         start;
      heap_op_type  op;
      heap_sel_type sel;
      sample_type   value;
   } heap_cmd_type;

   // status from the heap unit
   typedef struct packed {
      logic             done;
      sample_type       top_lo;
      sample_type       top_hi;
      logic [CNT_W-1:0] cnt_lo;
      logic [CNT_W-1:0] cnt_hi;
      sample_type       removed;
   } heap_stat_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_UP_RD,
      U_UP_CMP,
      U_RM_RD,
      U_RM_LAST,
      U_DN_RDL,
      U_DN_RDR,
      U_DN_CMP
   } unit_state_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_INS,
      T_CHK1,
      T_CHK2,
      T_CHK3,
      T_MV_RM,
      T_MV_IN,
      T_OUT
   } top_state_type;

   // heap order: max-heap for the lower half, min-heap for the upper half
   function automatic logic outranks(sample_type a, sample_type b, heap_sel_type sel);
      outranks = (sel == HEAP_LOWER) ? (a > b) : (a < b);
   endfunction

endpackage

FILE: rtl/core/rmh_heap_ram.sv
`timescale 1ns / 1ps
module rmh_heap_ram #(
   parameter int DEPTH = 514,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/rmh_heap_unit.sv
`timescale 1ns / 1ps
module rmh_heap_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  rmh_pkg::heap_cmd_type cmd,
   output rmh_pkg::heap_stat_type stat
);

   localparam int IW = rmh_pkg::IDX_W;
   localparam int CW = rmh_pkg::CNT_W;

   rmh_pkg::unit_state_type state_ff, state_in;
   rmh_pkg::heap_sel_type   sel_ff, sel_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           n_ff, n_in;
   rmh_pkg::sample_type     val_ff, val_in;
   rmh_pkg::sample_type     lch_ff, lch_in;
   rmh_pkg::sample_type     rm_ff, rm_in;
   rmh_pkg::sample_type     top_lo_ff, top_lo_in, top_hi_ff, top_hi_in;
   logic [CW-1:0]           cnt_lo_ff, cnt_lo_in, cnt_hi_ff, cnt_hi_in;
   logic                    done_ff, done_in;

   logic                we;
   logic [IW-1:0]       waddr, raddr;
   rmh_pkg::sample_type wdata, rdata, rdata_lo, rdata_hi;
   logic [IW:0]         lch_idx, rch_idx;
   logic [IW-1:0]       par_idx;
   logic                rd_win, up_win, l_win, r_win;
   rmh_pkg::sample_type cand;

   // heap memories
   rmh_heap_ram #(.DEPTH(rmh_pkg::HEAP_DEPTH), .WIDTH(rmh_pkg::SAMPLE_WIDTH)) u_ram_lo (
      .clock (clock),
      .we    (we && (sel_ff == rmh_pkg::HEAP_LOWER)),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata_lo)
   );

   rmh_heap_ram #(.DEPTH(rmh_pkg::HEAP_DEPTH), .WIDTH(rmh_pkg::SAMPLE_WIDTH)) u_ram_hi (
      .clock (clock),
      .we    (we && (sel_ff == rmh_pkg::HEAP_UPPER)),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata_hi)
   );

   assign rdata   = (sel_ff == rmh_pkg::HEAP_LOWER) ? rdata_lo : rdata_hi;
   assign lch_idx = {idx_ff, 1'b1};
   assign rch_idx = lch_idx + 1'b1;
   assign par_idx = IW'((idx_ff - 1'b1) >> 1);
   assign rd_win  = rmh_pkg::outranks(rdata, val_ff, sel_ff);
   // sift up moves on while the carried value beats its parent
   assign up_win  = rmh_pkg::outranks(val_ff, rdata, sel_ff);
   assign l_win   = rmh_pkg::outranks(lch_ff, val_ff, sel_ff);
   assign cand    = l_win ? lch_ff : val_ff;
   assign r_win   = rmh_pkg::outranks(rdata, cand, sel_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmh_pkg::U_IDLE: begin
            if (cmd.start) begin
               state_in = (cmd.op == rmh_pkg::OP_INSERT) ? rmh_pkg::U_UP_RD : rmh_pkg::U_RM_RD;
            end
         end
         rmh_pkg::U_UP_RD: begin
            state_in = (idx_ff == '0) ? rmh_pkg::U_IDLE : rmh_pkg::U_UP_CMP;
         end
         rmh_pkg::U_UP_CMP: begin
            state_in = up_win ? rmh_pkg::U_UP_RD : rmh_pkg::U_IDLE;
         end
         rmh_pkg::U_RM_RD:   state_in = rmh_pkg::U_RM_LAST;
         rmh_pkg::U_RM_LAST: state_in = rmh_pkg::U_DN_RDL;
         rmh_pkg::U_DN_RDL: begin
            state_in = (lch_idx >= (IW+1)'(n_ff)) ? rmh_pkg::U_IDLE : rmh_pkg::U_DN_RDR;
         end
         rmh_pkg::U_DN_RDR: begin
            if (rch_idx < (IW+1)'(n_ff)) begin
               state_in = rmh_pkg::U_DN_CMP;
            end else begin
               state_in = rd_win ? rmh_pkg::U_DN_RDL : rmh_pkg::U_IDLE;
            end
         end
         rmh_pkg::U_DN_CMP: begin
            state_in = (r_win || l_win) ? rmh_pkg::U_DN_RDL : rmh_pkg::U_IDLE;
         end
         default: state_in = rmh_pkg::U_IDLE;
      endcase
   end

   // datapath and memory access
   always_comb begin
      sel_in    = sel_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      val_in    = val_ff;
      lch_in    = lch_ff;
      rm_in     = rm_ff;
      cnt_lo_in = cnt_lo_ff;
      cnt_hi_in = cnt_hi_ff;
      done_in   = 1'b0;
      we        = 1'b0;
      waddr     = idx_ff;
      wdata     = val_ff;
      raddr     = '0;
      unique case (state_ff)
         rmh_pkg::U_IDLE: begin
            if (cmd.start) begin
               sel_in = cmd.sel;
               if (cmd.op == rmh_pkg::OP_INSERT) begin
                  val_in = cmd.value;
                  if (cmd.sel == rmh_pkg::HEAP_LOWER) begin
                     idx_in    = IW'(cnt_lo_ff);
                     cnt_lo_in = cnt_lo_ff + 1'b1;
                  end else begin
                     idx_in    = IW'(cnt_hi_ff);
                     cnt_hi_in = cnt_hi_ff + 1'b1;
                  end
               end else begin
                  if (cmd.sel == rmh_pkg::HEAP_LOWER) begin
                     rm_in     = top_lo_ff;
                     n_in      = cnt_lo_ff - 1'b1;
                     cnt_lo_in = cnt_lo_ff - 1'b1;
                  end else begin
                     rm_in     = top_hi_ff;
                     n_in      = cnt_hi_ff - 1'b1;
                     cnt_hi_in = cnt_hi_ff - 1'b1;
                  end
               end
            end
         end
         // sift up: carry the new value toward the root
         rmh_pkg::U_UP_RD: begin
            raddr = par_idx;
            if (idx_ff == '0) begin
               we      = 1'b1;
               done_in = 1'b1;
            end
         end
         rmh_pkg::U_UP_CMP: begin
            we = 1'b1;
            if (up_win) begin
               wdata  = rdata;
               idx_in = par_idx;
            end else begin
               done_in = 1'b1;
            end
         end
         // fetch the last element to refill the root
         rmh_pkg::U_RM_RD: begin
            raddr = IW'(n_ff);
         end
         rmh_pkg::U_RM_LAST: begin
            val_in = rdata;
            idx_in = '0;
         end
         // sift down: compare with both children, or with the left one alone when there is no right child
         rmh_pkg::U_DN_RDL: begin
            raddr = lch_idx[IW-1:0];
            if (lch_idx >= (IW+1)'(n_ff)) begin
               we      = 1'b1;
               done_in = 1'b1;
            end
         end
         rmh_pkg::U_DN_RDR: begin
            lch_in = rdata;
            raddr  = rch_idx[IW-1:0];
            if (rch_idx >= (IW+1)'(n_ff)) begin
               we = 1'b1;
               if (rd_win) begin
                  wdata  = rdata;
                  idx_in = lch_idx[IW-1:0];
               end else begin
                  done_in = 1'b1;
               end
            end
         end
         rmh_pkg::U_DN_CMP: begin
            we = 1'b1;
            if (r_win) begin
               wdata  = rdata;
               idx_in = rch_idx[IW-1:0];
            end else if (l_win) begin
               wdata  = lch_ff;
               idx_in = lch_idx[IW-1:0];
            end else begin
               done_in = 1'b1;
            end
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   // root values kept beside the memories
   always_comb begin
      top_lo_in = top_lo_ff;
      top_hi_in = top_hi_ff;
      if (we && (waddr == '0)) begin
         if (sel_ff == rmh_pkg::HEAP_LOWER) begin
            top_lo_in = wdata;
         end else begin
            top_hi_in = wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rmh_pkg::U_IDLE;
         cnt_lo_ff <= '0;
         cnt_hi_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_lo_ff <= cnt_lo_in;
         cnt_hi_ff <= cnt_hi_in;
         done_ff   <= done_in;
      end
      sel_ff    <= sel_in;
      idx_ff    <= idx_in;
      n_ff      <= n_in;
      val_ff    <= val_in;
      lch_ff    <= lch_in;
      rm_ff     <= rm_in;
      top_lo_ff <= top_lo_in;
      top_hi_ff <= top_hi_in;
   end

   assign stat.done    = done_ff;
   assign stat.top_lo  = top_lo_ff;
   assign stat.top_hi  = top_hi_ff;
   assign stat.cnt_lo  = cnt_lo_ff;
   assign stat.cnt_hi  = cnt_hi_ff;
   assign stat.removed = rm_ff;

endmodule

FILE: rtl/core/running_median_two_heaps_core.sv
`timescale 1ns / 1ps
// Running median over a stream of signed 32-bit samples, kept as a max-heap
// for the lower half and a min-heap for the upper half, each in its own
// single-port-read RAM of 514 entries. Each accepted beat returns one beat with
// twice the median (33 bits, exact halves), the number of samples held and a
// dropped flag; once 1024 samples are held, new samples are ignored and flagged.
// One sample takes one heap insert with sift-up and up to two moves between
// heaps, each a sift-down and a sift-up; the run time is set by the heap depth
// and the one-read-per-cycle RAM port. A full store skips the heaps and goes
// straight to the result. The next sample is taken while a result still waits.
module running_median_two_heaps_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [32:0] median_doubled, [43:33] stored_count, zero pad
   output logic        rsp_tuser   // [0] dropped
);

   rmh_pkg::top_state_type state_ff, state_in;
   rmh_pkg::top_state_type ret_ff, ret_in;
   rmh_pkg::heap_sel_type  src_ff, src_in;
   logic                   drop_ff, drop_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [rmh_pkg::MED_W-1:0]   med_ff, med_in;
   logic [rmh_pkg::TOTAL_W-1:0] cnt_ff, cnt_in;
   logic                   drop_out_ff, drop_out_in;

   rmh_pkg::heap_cmd_type  cmd;
   rmh_pkg::heap_stat_type stat;

   logic                        accept, full, load;
   logic [rmh_pkg::TOTAL_W-1:0] total;
   logic                        need1, need2, need3;
   logic [rmh_pkg::MED_W-1:0]   median;

   rmh_heap_unit u_heap (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign req_tready = (state_ff == rmh_pkg::T_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign total      = rmh_pkg::TOTAL_W'(stat.cnt_lo) + rmh_pkg::TOTAL_W'(stat.cnt_hi);
   assign full       = (total >= rmh_pkg::TOTAL_W'(rmh_pkg::CAPACITY));
   assign load       = (state_ff == rmh_pkg::T_OUT) && (!rsp_valid_ff || rsp_tready);

   // rebalance checks
   assign need1 = (stat.cnt_hi != '0) && (stat.top_lo > stat.top_hi);
   assign need2 = rmh_pkg::TOTAL_W'(stat.cnt_lo) > rmh_pkg::TOTAL_W'(stat.cnt_hi) + 1'b1;
   assign need3 = rmh_pkg::TOTAL_W'(stat.cnt_hi) > rmh_pkg::TOTAL_W'(stat.cnt_lo) + 1'b1;

   // median times two
   always_comb begin
      if (stat.cnt_lo == '0 && stat.cnt_hi == '0) begin
         median = '0;
      end else if (stat.cnt_lo == stat.cnt_hi) begin
         median = rmh_pkg::MED_W'($signed(stat.top_lo)) + rmh_pkg::MED_W'($signed(stat.top_hi));
      end else if (stat.cnt_lo > stat.cnt_hi) begin
         median = {stat.top_lo, 1'b0};
      end else begin
         median = {stat.top_hi, 1'b0};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmh_pkg::T_IDLE: begin
            if (accept) begin
               state_in = full ? rmh_pkg::T_OUT : rmh_pkg::T_INS;
            end
         end
         rmh_pkg::T_INS: if (stat.done) state_in = rmh_pkg::T_CHK1;
         rmh_pkg::T_CHK1: state_in = need1 ? rmh_pkg::T_MV_RM : rmh_pkg::T_CHK2;
         rmh_pkg::T_CHK2: state_in = need2 ? rmh_pkg::T_MV_RM : rmh_pkg::T_CHK3;
         rmh_pkg::T_CHK3: state_in = need3 ? rmh_pkg::T_MV_RM : rmh_pkg::T_OUT;
         rmh_pkg::T_MV_RM: if (stat.done) state_in = rmh_pkg::T_MV_IN;
         rmh_pkg::T_MV_IN: if (stat.done) state_in = ret_ff;
         rmh_pkg::T_OUT: if (load) state_in = rmh_pkg::T_IDLE;
         default: state_in = rmh_pkg::T_IDLE;
      endcase
   end

   // heap commands and result capture
   always_comb begin
      cmd          = '0;
      ret_in       = ret_ff;
      src_in       = src_ff;
      drop_in      = drop_ff;
      med_in       = med_ff;
      cnt_in       = cnt_ff;
      drop_out_in  = drop_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         rmh_pkg::T_IDLE: begin
            if (accept) begin
               drop_in = full;
               if (!full) begin
                  cmd.start = 1'b1;
                  cmd.op    = rmh_pkg::OP_INSERT;
                  cmd.sel   = rmh_pkg::HEAP_LOWER;
                  cmd.value = req_tdata[rmh_pkg::SAMPLE_WIDTH-1:0];
               end
            end
         end
         rmh_pkg::T_CHK1, rmh_pkg::T_CHK2, rmh_pkg::T_CHK3: begin
            if ((state_ff == rmh_pkg::T_CHK1 && need1) ||
                (state_ff == rmh_pkg::T_CHK2 && need2) ||
                (state_ff == rmh_pkg::T_CHK3 && need3)) begin
               src_in    = (state_ff == rmh_pkg::T_CHK3) ? rmh_pkg::HEAP_UPPER
                                                         : rmh_pkg::HEAP_LOWER;
               ret_in    = (state_ff == rmh_pkg::T_CHK1) ? rmh_pkg::T_CHK2 :
                           (state_ff == rmh_pkg::T_CHK2) ? rmh_pkg::T_CHK3 : rmh_pkg::T_OUT;
               cmd.start = 1'b1;
               cmd.op    = rmh_pkg::OP_REMOVE;
               cmd.sel   = src_in;
            end
         end
         rmh_pkg::T_MV_RM: begin
            if (stat.done) begin
               cmd.start = 1'b1;
               cmd.op    = rmh_pkg::OP_INSERT;
               cmd.sel   = (src_ff == rmh_pkg::HEAP_LOWER) ? rmh_pkg::HEAP_UPPER
                                                          : rmh_pkg::HEAP_LOWER;
               cmd.value = stat.removed;
            end
         end
         rmh_pkg::T_OUT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               med_in       = median;
               cnt_in       = total;
               drop_out_in  = drop_ff;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmh_pkg::T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff      <= ret_in;
      src_ff      <= src_in;
      drop_ff     <= drop_in;
      med_ff      <= med_in;
      cnt_ff      <= cnt_in;
      drop_out_ff <= drop_out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, cnt_ff, med_ff};
   assign rsp_tuser  = drop_out_ff;

endmodule

FILE: tb/sv/running_median_checker.sv
`timescale 1ns / 1ps
module running_median_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending_count,
   output int          result_count,
   output int          drop_count
);

   typedef struct packed {
      logic [32:0] median2;
      logic [10:0] held;
      logic        dropped;
   } median_result_type;

   // sorted copy of every sample held; the median follows from the sort
   longint held_samples[$];
   median_result_type median_queue[$];
   logic [32:0] last_median2;

   function automatic median_result_type median_after(logic [31:0] raw);
      median_result_type r;
      longint v;
      int n, pos;
      longint m2;
      v = longint'($signed(raw));
      r.dropped = 1'b0;
      if (held_samples.size() >= rmh_pkg::CAPACITY) begin
         r.dropped = 1'b1;
         r.median2 = last_median2;
         r.held = 11'(held_samples.size());
         return r;
      end
      pos = 0;
      while (pos < held_samples.size() && held_samples[pos] < v) pos++;
      held_samples.insert(pos, v);
      n = held_samples.size();
      // odd counts take the middle sample, even counts the sum of the two middle ones
      if (n % 2 == 1) m2 = 2 * held_samples[n / 2];
      else m2 = held_samples[n / 2 - 1] + held_samples[n / 2];
      r.median2 = m2[32:0];
      r.held = 11'(n);
      last_median2 = r.median2;
      return r;
   endfunction

   // predict on each input beat, compare on each output beat
   always @(posedge clock) begin
      median_result_type got, want;
      if (reset) begin
         held_samples.delete();
         median_queue.delete();
         last_median2 = '0;
         fail_count <= 0;
         result_count <= 0;
         drop_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready) median_queue.push_back(median_after(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[32:0], rsp_tdata[43:33], rsp_tuser};
            result_count <= result_count + 1;
            if (rsp_tuser) drop_count <= drop_count + 1;
            if (median_queue.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = median_queue.pop_front();
               if (got.median2 !== want.median2 || got.held !== want.held
                   || got.dropped !== want.dropped) begin
                  $display("%0t: expected median2 %h held %0d dropped %b, got %h %0d %b",
                           $time, want.median2, want.held, want.dropped,
                           got.median2, got.held, got.dropped);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= median_queue.size();
      end
   end
endmodule

FILE: tb/sv/running_median_two_heaps_core_tb.sv
`timescale 1ns / 1ps
module running_median_two_heaps_core_tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   int fail_count, pending_count, result_count, drop_count;
   longint cycles = 0;

   localparam longint CYCLE_LIMIT = 2000000;

   running_median_two_heaps_core DUT (.*);
   running_median_checker checker_i (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 19);
      if (k < 10) return 0;
      if (k < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side stalls at random, with calm stretches
   initial begin
      int g;
      forever begin
         @(posedge clock);
         g = (cycles % 4000 < 1000) ? 0 : gap_len();
         rsp_tready <= (g == 0);
         repeat (g) @(posedge clock);
         if (g != 0) rsp_tready <= 1'b1;
      end
   end

   task automatic send_sample(input logic [31:0] s);
      int g;
      req_tvalid <= 1'b1;
      req_tdata <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      g = (cycles % 5000 < 1200) ? 0 : gap_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_sample();
      int k;
      k = $urandom_range(0, 9);
      if (k < 5) return $urandom;
      if (k < 8) return 32'($signed($urandom_range(0, 40)) - 20);
      return (k == 8) ? 32'h7fffffff : 32'h80000000;
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // extremes, ties and alternating signs
      send_sample(32'h7fffffff);
      send_sample(32'h7fffffff);
      send_sample(32'h80000000);
      send_sample(32'h80000000);
      send_sample(32'h80000000);
      send_sample(32'h00000000);
      send_sample(32'hffffffff);
      send_sample(32'h00000001);
      send_sample(32'h55555555);
      send_sample(32'haaaaaaaa);
      send_sample(32'h00000005);
      send_sample(32'h00000005);
      // random part
      repeat (488) send_sample(pick_sample());
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("%0d results checked over extremes, ties and random samples with stalls",
               result_count);
      $display("%0d of them arrived with the store full", drop_count);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/core/rmh_pkg.sv
rtl/core/rmh_heap_ram.sv
rtl/core/rmh_heap_unit.sv
rtl/core/running_median_two_heaps_core.sv
tb/sv/running_median_checker.sv
tb/sv/running_median_two_heaps_core_tb.sv
